// File: rtl/core/integer_matrix_power_top_macros.svh
// ---------------------------------------------------------------------------
// Integer matrix power: assertion macros
// Shorthand for clocked implication checks that share clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_POWER_TOP_MACROS_SVH
`define INTEGER_MATRIX_POWER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IMP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/imp_pkg.sv
// ---------------------------------------------------------------------------
// Integer matrix power: shared package
// Sizes, request and result types, control structs and the sequencer states.
// ---------------------------------------------------------------------------
package imp_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_BITS  = 32;
  localparam int IDX_BITS   = 3;
  localparam int DIM_BITS   = 4;
  localparam int EXP_BITS   = 31;
  localparam int CELLS      = MAX_DIM * MAX_DIM;
  localparam int ADDR_BITS  = (CELLS > 1) ? $clog2(CELLS) : 1;
  // Work memory holds two result banks and two square banks.
  localparam int WORK_BANKS = 4;
  localparam int WORK_BITS  = ADDR_BITS + 2;
  // Cycles from an operand read to the product write-back.
  localparam int MAC_LAT    = 2;
  localparam int DRAIN_BITS = (MAC_LAT > 1) ? $clog2(MAC_LAT) : 1;

  typedef logic [ELEM_BITS-1:0] elem_t;

  typedef struct packed {
    logic                 mode;
    logic [IDX_BITS-1:0]  row_index;
    logic [IDX_BITS-1:0]  col_index;
    logic signed [31:0]   element_value;
    logic [EXP_BITS-1:0]  exponent;
  } imp_in_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]  out_row;
    logic [IDX_BITS-1:0]  out_col;
    logic signed [31:0]   out_value;
    logic                 last;
  } imp_out_t;

  // One multiply-accumulate step as issued by the sequencer.
  typedef struct packed {
    logic                valid;
    logic                first;
    logic                last;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
  } imp_tag_t;

  typedef struct packed {
    imp_tag_t            tag;
    logic                emit;
    logic                emit_last;
    logic [IDX_BITS-1:0] kk;
    logic                op_sq;
    logic                res_id;
    logic                sq_base;
    logic                res_bank;
    logic                sq_bank;
  } imp_ctl_t;

  typedef struct packed {
    logic                we;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    elem_t               data;
  } imp_wr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT,
    S_ISSUE,
    S_DRAIN,
    S_OUT
  } imp_state_t;

  function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [IDX_BITS-1:0] row,
                                                     input logic [IDX_BITS-1:0] col);
    return ADDR_BITS'(int'(row) * MAX_DIM + int'(col));
  endfunction

endpackage

// File: rtl/core/integer_matrix_power_top.sv
// ---------------------------------------------------------------------------
// Integer matrix power: top level
// Raises a loaded square matrix to a power by square-and-multiply.
// ---------------------------------------------------------------------------
// Usage. A request is taken on a rising edge with start high and busy low.
// A load request (mode 0) writes one element of the base matrix in that
// cycle and produces no result; loads can follow each other every cycle.
// A run request (mode 1) raises the base matrix, over the size in use set
// through cfg_we/cfg_data, to the given exponent. Busy stays high while a
// run is computed and its results are read out. Each matrix product is done
// by one shared multiply-accumulate unit, one inner-product term per cycle.
// A run does up to 61 products. The results appear row-major on out_data,
// one per cycle, starting in the cycle after the first output cycle, each
// marked by out_valid for a single cycle, with last set on the final
// element, which is shown in the first cycle after busy falls. The receiver
// cannot stall the block; it must take each result in the cycle it is shown.
// Exponent zero gives the identity. Reset sets the size to eight and marks
// every base element as zero through per-element valid bits; no clearing
// pass runs.
// ---------------------------------------------------------------------------
`include "integer_matrix_power_top_macros.svh"

module integer_matrix_power_top
  import imp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  imp_in_t             in_data,
  output logic                out_valid,
  output imp_out_t            out_data,
  input  logic                cfg_we,
  input  logic [DIM_BITS-1:0] cfg_data
);

  logic [DIM_BITS-1:0] size_r, size_nxt;
  logic [CELLS-1:0]    base_vld_r, base_vld_nxt;

  logic req_acc, load_acc, run_acc, load_ok;
  logic [ADDR_BITS-1:0] load_cell, cell_a, cell_b;
  logic [IDX_BITS-1:0]  a_col;
  elem_t                load_val;

  imp_ctl_t ctl;
  imp_wr_t  wr;

  logic [1:0]           bank_a, bank_b, bank_w;
  logic [WORK_BITS-1:0] work_ra, work_rb, work_wa;
  elem_t                work_da, work_db, base_da, base_db;
  elem_t                base_a, base_b, ident, opa, opb;

  // Values registered alongside the memory read.
  logic id_a_r, base_va_r, base_vb_r;
  logic emit_r, emit_last_r;
  logic [IDX_BITS-1:0] emit_row_r, emit_col_r;

  // Request decode. The base matrix is only written by loads.
  assign req_acc   = start && !busy;
  assign load_acc  = req_acc && !in_data.mode;
  assign run_acc   = req_acc && in_data.mode;
  assign load_ok   = (int'(in_data.row_index) < MAX_DIM) &&
                     (int'(in_data.col_index) < MAX_DIM);
  assign load_cell = cell_addr(in_data.row_index, in_data.col_index);
  assign load_val  = ELEM_BITS'(in_data.element_value);

  always_comb begin
    size_nxt     = cfg_we ? cfg_data : size_r;
    base_vld_nxt = base_vld_r;
    if (load_acc && load_ok) begin
      base_vld_nxt[load_cell] = 1'b1;
    end
  end

  imp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .run      (run_acc),
    .exponent (in_data.exponent),
    .size     (size_r),
    .busy     (busy),
    .ctl      (ctl)
  );

  // Read addresses. Port A walks row r of the left operand (or the result
  // matrix while emitting), port B walks column c of the right operand.
  // The work memory is split into result banks 0/1 and square banks 2/3;
  // each product lands in the idle bank of its kind and then the banks swap.
  always_comb begin
    a_col   = ctl.emit ? ctl.tag.col : ctl.kk;
    cell_a  = cell_addr(ctl.tag.row, a_col);
    cell_b  = cell_addr(ctl.kk, ctl.tag.col);
    bank_a  = (ctl.op_sq && !ctl.emit) ? {1'b1, ctl.sq_bank} : {1'b0, ctl.res_bank};
    bank_b  = {1'b1, ctl.sq_bank};
    bank_w  = ctl.op_sq ? {1'b1, !ctl.sq_bank} : {1'b0, !ctl.res_bank};
    work_ra = {bank_a, cell_a};
    work_rb = {bank_b, cell_b};
    work_wa = {bank_w, cell_addr(wr.row, wr.col)};
  end

  imp_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (CELLS)
  ) u_base_ram (
    .clk     (clk),
    .we      (load_acc && load_ok),
    .waddr   (load_cell),
    .wdata   (load_val),
    .raddr_a (cell_a),
    .raddr_b (cell_b),
    .rdata_a (base_da),
    .rdata_b (base_db)
  );

  imp_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (WORK_BANKS * CELLS)
  ) u_work_ram (
    .clk     (clk),
    .we      (wr.we),
    .waddr   (work_wa),
    .wdata   (wr.data),
    .raddr_a (work_ra),
    .raddr_b (work_rb),
    .rdata_a (work_da),
    .rdata_b (work_db)
  );

  // Operand selection in the cycle after the read. Until the first product
  // into each, the result is the identity and the square is the base matrix;
  // a base element never loaded reads as zero.
  always_comb begin
    ident  = ELEM_BITS'(id_a_r);
    base_a = base_va_r ? base_da : '0;
    base_b = base_vb_r ? base_db : '0;
    if (ctl.op_sq) begin
      opa = ctl.sq_base ? base_a : work_da;
    end else begin
      opa = ctl.res_id ? ident : work_da;
    end
    opb = ctl.sq_base ? base_b : work_db;
  end

  imp_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .tag   (ctl.tag),
    .opa   (opa),
    .opb   (opb),
    .wr    (wr)
  );

  // Results leave in the cycle after their read is issued.
  always_comb begin
    out_valid          = emit_r;
    out_data.out_row   = emit_row_r;
    out_data.out_col   = emit_col_r;
    out_data.out_value = 32'(ctl.res_id ? ident : work_da);
    out_data.last      = emit_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= DIM_BITS'(MAX_DIM);
      base_vld_r <= '0;
      emit_r     <= 1'b0;
    end else begin
      size_r     <= size_nxt;
      base_vld_r <= base_vld_nxt;
      emit_r     <= ctl.emit;
    end
    id_a_r      <= (ctl.tag.row == a_col);
    base_va_r   <= base_vld_r[cell_a];
    base_vb_r   <= base_vld_r[cell_b];
    emit_last_r <= ctl.emit_last;
    emit_row_r  <= ctl.tag.row;
    emit_col_r  <= ctl.tag.col;
  end

  // Product write-back only happens inside a run.
  `IMP_ASSERT_SAME(a_wr_in_run, wr.we, busy, "product write outside a run")
  // Emission and computation never overlap.
  `IMP_ASSERT_SAME(a_wr_no_out, wr.we, !out_valid, "write-back during result output")
  // The final result of a run is followed by a gap.
  `IMP_ASSERT_NEXT(a_last_gap, out_valid && out_data.last, !out_valid,
                   "result right after the final element")
  // A run request makes the block busy.
  `IMP_ASSERT_NEXT(a_run_busy, start && !busy && in_data.mode, busy,
                   "run request did not start a run")

endmodule

// File: rtl/core/imp_ram.sv
// ---------------------------------------------------------------------------
// Integer matrix power: generic RAM
// One write port and two read ports, read data registered.
// ---------------------------------------------------------------------------
module imp_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

// File: rtl/core/imp_mac.sv
// ---------------------------------------------------------------------------
// Integer matrix power: multiply-accumulate unit
// Registered multiply followed by a wrapping accumulator and write-back.
// ---------------------------------------------------------------------------
module imp_mac
  import imp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  imp_tag_t tag,
  input  elem_t    opa,
  input  elem_t    opb,
  output imp_wr_t  wr
);

  imp_tag_t tag1_r, tag2_r;
  elem_t    prod_r, prod_nxt;
  elem_t    acc_r, acc_nxt, acc_sum;

  // Products and sums keep only the low ELEM_BITS bits.
  always_comb begin
    prod_nxt = opa * opb;
    acc_sum  = tag2_r.first ? prod_r : acc_r + prod_r;
    acc_nxt  = tag2_r.valid ? acc_sum : acc_r;
    wr.we    = tag2_r.valid && tag2_r.last;
    wr.row   = tag2_r.row;
    wr.col   = tag2_r.col;
    wr.data  = acc_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag;
      tag2_r <= tag1_r;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

// File: rtl/core/imp_ctrl.sv
// ---------------------------------------------------------------------------
// Integer matrix power: sequencer
// Walks the exponent bits and sweeps row, column and inner index counters.
// ---------------------------------------------------------------------------
module imp_ctrl
  import imp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                run,
  input  logic [EXP_BITS-1:0] exponent,
  input  logic [DIM_BITS-1:0] size,
  output logic                busy,
  output imp_ctl_t            ctl
);

  imp_state_t          state_r, state_nxt;
  logic [EXP_BITS-1:0] exp_r, exp_nxt;
  logic [DIM_BITS-1:0] n_r, n_nxt, n_clamp;
  logic [IDX_BITS-1:0] r_r, r_nxt, c_r, c_nxt, k_r, k_nxt, nm1;
  logic [DRAIN_BITS-1:0] drain_r, drain_nxt;
  logic op_sq_r, op_sq_nxt, res_id_r, res_id_nxt, sq_base_r, sq_base_nxt;
  logic res_bank_r, res_bank_nxt, sq_bank_r, sq_bank_nxt;
  logic last_k, last_c, last_r, drain_done;

  always_comb begin
    if (size == '0) begin
      n_clamp = DIM_BITS'(1);
    end else if (int'(size) > MAX_DIM) begin
      n_clamp = DIM_BITS'(MAX_DIM);
    end else begin
      n_clamp = size;
    end
  end

  assign nm1        = IDX_BITS'(n_r - DIM_BITS'(1));
  assign last_k     = (k_r == nm1);
  assign last_c     = (c_r == nm1);
  assign last_r     = (r_r == nm1);
  assign drain_done = (drain_r == DRAIN_BITS'(MAC_LAT - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (run) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (exp_r == '0) begin
          state_nxt = S_OUT;
        end else if (exp_r[0]) begin
          state_nxt = S_ISSUE;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        state_nxt = (exp_r[EXP_BITS-1:1] != '0) ? S_ISSUE : S_OUT;
      end
      S_ISSUE: begin
        if (last_k && last_c && last_r) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (drain_done) state_nxt = op_sq_r ? S_CHECK : S_SHIFT;
      end
      S_OUT: begin
        if (last_c && last_r) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Counters, exponent and bank bookkeeping.
  always_comb begin
    exp_nxt      = exp_r;
    n_nxt        = n_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    k_nxt        = k_r;
    drain_nxt    = drain_r;
    op_sq_nxt    = op_sq_r;
    res_id_nxt   = res_id_r;
    sq_base_nxt  = sq_base_r;
    res_bank_nxt = res_bank_r;
    sq_bank_nxt  = sq_bank_r;
    case (state_r)
      S_IDLE: begin
        if (run) begin
          exp_nxt      = exponent;
          n_nxt        = n_clamp;
          r_nxt        = '0;
          c_nxt        = '0;
          k_nxt        = '0;
          drain_nxt    = '0;
          res_id_nxt   = 1'b1;
          sq_base_nxt  = 1'b1;
          res_bank_nxt = 1'b0;
          sq_bank_nxt  = 1'b0;
        end
      end
      S_CHECK: begin
        op_sq_nxt = 1'b0;
      end
      S_SHIFT: begin
        exp_nxt   = exp_r >> 1;
        op_sq_nxt = 1'b1;
      end
      S_ISSUE: begin
        if (!last_k) begin
          k_nxt = k_r + IDX_BITS'(1);
        end else begin
          k_nxt = '0;
          if (!last_c) begin
            c_nxt = c_r + IDX_BITS'(1);
          end else begin
            c_nxt = '0;
            r_nxt = last_r ? '0 : r_r + IDX_BITS'(1);
          end
        end
      end
      S_DRAIN: begin
        if (drain_done) begin
          drain_nxt = '0;
          if (op_sq_r) begin
            sq_bank_nxt = !sq_bank_r;
            sq_base_nxt = 1'b0;
          end else begin
            res_bank_nxt = !res_bank_r;
            res_id_nxt   = 1'b0;
          end
        end else begin
          drain_nxt = drain_r + DRAIN_BITS'(1);
        end
      end
      S_OUT: begin
        if (!last_c) begin
          c_nxt = c_r + IDX_BITS'(1);
        end else begin
          c_nxt = '0;
          r_nxt = last_r ? '0 : r_r + IDX_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  // Outputs.
  always_comb begin
    busy          = (state_r != S_IDLE);
    ctl.tag.valid = (state_r == S_ISSUE);
    ctl.tag.first = (k_r == '0);
    ctl.tag.last  = last_k;
    ctl.tag.row   = r_r;
    ctl.tag.col   = c_r;
    ctl.emit      = (state_r == S_OUT);
    ctl.emit_last = last_r && last_c;
    ctl.kk        = k_r;
    ctl.op_sq     = op_sq_r;
    ctl.res_id    = res_id_r;
    ctl.sq_base   = sq_base_r;
    ctl.res_bank  = res_bank_r;
    ctl.sq_bank   = sq_bank_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      exp_r   <= '0;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      exp_r   <= exp_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
      drain_r <= drain_nxt;
    end
    n_r        <= n_nxt;
    op_sq_r    <= op_sq_nxt;
    res_id_r   <= res_id_nxt;
    sq_base_r  <= sq_base_nxt;
    res_bank_r <= res_bank_nxt;
    sq_bank_r  <= sq_bank_nxt;
  end

endmodule

// File: test/tb_integer_matrix_power_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Integer matrix power: testbench
// Drives load and run requests into the block and checks every emitted
// matrix element. A short directed script covers the size extremes, the
// element extremes, exponent zero and the widest exponent. Randomized
// phases follow, each setting a size, usually loading a matrix and then raising it to up to three powers.
// ---------------------------------------------------------------------------
module tb_integer_matrix_power_top;
  import imp_pkg::*;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  localparam int     RANDOM_ITEMS  = 480;
  // Idle cycles granted after the last result before a size write.
  localparam int     SETTLE_CYCLES = 8;
  localparam int     DRAIN_CYCLES  = 64;
  // Small sizes dominate the random phases; this bound is many times the
  // slowest legal run (size eight, every exponent bit set).
  localparam longint CYCLE_LIMIT   = 15_000_000;

  typedef elem_t grid_t [0:CELLS-1];

  typedef enum logic [1:0] {
    STEP_CFG,
    STEP_LOAD,
    STEP_RUN
  } step_kind_t;

  // How the expected matrix of a run is obtained: computed by the power
  // predictor, or read off directly as identity, zero or a plain diagonal.
  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_IDENTITY,
    EXP_ZERO,
    EXP_DIAG
  } result_form_t;

  typedef struct packed {
    step_kind_t          kind;
    logic [DIM_BITS-1:0] size;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic [31:0]         value;
    logic [EXP_BITS-1:0] power;
    result_form_t        form;
    logic [31:0]         diag;
  } step_t;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                start    = 1'b0;
  logic                busy;
  imp_in_t             in_data  = '0;
  logic                out_valid;
  imp_out_t            out_data;
  logic                cfg_we   = 1'b0;
  logic [DIM_BITS-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  integer_matrix_power_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Predictor state: the loaded matrix and the size register as written.
  grid_t               loaded_elems;
  logic [DIM_BITS-1:0] size_setting = 4'd8;
  imp_out_t            pending_elems [$];

  int     errors     = 0;
  longint cycles     = 0;
  int     burst_left = 0;

  // Directed script. Rows with a typed form carry their answer directly;
  // the rest go through the predictor.
  step_t script [0:24] = '{
    // Straight out of reset: size eight, all-zero base.
    '{STEP_RUN,  4'd0,  3'd0, 3'd0, 32'd0,         31'd0,         EXP_IDENTITY, 32'd0},
    '{STEP_RUN,  4'd0,  3'd0, 3'd0, 32'd0,         31'd7,         EXP_ZERO,     32'd0},
    // One by one: powers of the element extremes.
    '{STEP_CFG,  4'd1,  3'd0, 3'd0, 32'd0,         31'd0,         EXP_MODEL,    32'd0},
    '{STEP_LOAD, 4'd0,  3'd0, 3'd0, 32'hFFFF_FFFF, 31'd0,         EXP_MODEL,    32'd0},
    '{STEP_RUN,  4'd0,  3'd0, 3'd0, 32'd0,         31'h7FFF_FFFF, EXP_DIAG,     32'hFFFF_FFFF},
    '{STEP_RUN,  4'd0,  3'd0, 3'd0, 32'd0,         31'h4000_0000, EXP_IDENTITY, 32'd0},
    '{STEP_LOAD, 4'd0,  3'd0, 3'd0, 32'h8000_0000, 31'd0,         EXP_MODEL,    32'd0},
    '{STEP_RUN,  4'd0,  3'd0, 3'd0, 32'd0,         31'd2,         EXP_ZERO,     32'd0},
    '{STEP_RUN,  4'd0,  3'd0, 3'd0, 32'd0,         31'd1,         EXP_DIAG,     32'h8000_0000},
    '{STEP_LOAD, 4'd0,  3'd0, 3'd0, 32'h7FFF_FFFF, 31'd0,         EXP_MODEL,    32'd0},
    '{STEP_RUN,  4'd0,  3'd0, 3'd0, 32'd0,         31'd1,         EXP_DIAG,     32'h7FFF_FFFF},
    // A size of zero behaves as one.
    '{STEP_CFG,  4'd0,  3'd0, 3'd0, 32'd0,         31'd0,         EXP_MODEL,    32'd0},
    '{STEP_RUN,  4'd0,  3'd0, 3'd0, 32'd0,         31'd0,         EXP_IDENTITY, 32'd0},
    '{STEP_RUN,  4'd0,  3'd0, 3'd0, 32'd0,         31'd3,         EXP_MODEL,    32'd0},
    // Two by two, with loads outside the size in use that stay dormant.
    '{STEP_CFG,  4'd2,  3'd0, 3'd0, 32'd0,         31'd0,         EXP_MODEL,    32'd0},
    '{STEP_LOAD, 4'd0,  3'd0, 3'd1, 32'd1,         31'd0,         EXP_MODEL,    32'd0},
    '{STEP_LOAD, 4'd0,  3'd1, 3'd0, 32'd1,         31'd0,         EXP_MODEL,    32'd0},
    '{STEP_LOAD, 4'd0,  3'd7, 3'd7, 32'd5,         31'd0,         EXP_MODEL,    32'd0},
    '{STEP_LOAD, 4'd0,  3'd5, 3'd2, 32'h1234_5678, 31'd0,         EXP_MODEL,    32'd0},
    '{STEP_RUN,  4'd0,  3'd0, 3'd0, 32'd0,         31'd10,        EXP_MODEL,    32'd0},
    // An oversized setting saturates to eight and wakes the dormant loads.
    '{STEP_CFG,  4'd15, 3'd0, 3'd0, 32'd0,         31'd0,         EXP_MODEL,    32'd0},
    '{STEP_RUN,  4'd0,  3'd0, 3'd0, 32'd0,         31'd1,         EXP_MODEL,    32'd0},
    '{STEP_RUN,  4'd0,  3'd0, 3'd0, 32'd0,         31'h7FFF_FFFF, EXP_MODEL,    32'd0},
    '{STEP_CFG,  4'd8,  3'd0, 3'd0, 32'd0,         31'd0,         EXP_MODEL,    32'd0},
    '{STEP_RUN,  4'd0,  3'd0, 3'd0, 32'd0,         31'd5,         EXP_MODEL,    32'd0}
  };

  function automatic int active_dim();
    int n;
    n = int'(size_setting);
    if (n == 0) n = 1;
    if (n > MAX_DIM) n = MAX_DIM;
    return n;
  endfunction

  // Wrapping product over the top-left n by n corner.
  function automatic void mat_mult(output grid_t prod, input grid_t a, input grid_t b,
                                   input int n);
    elem_t sum;
    foreach (prod[i]) prod[i] = '0;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        sum = '0;
        for (int k = 0; k < n; k++) sum += a[r*MAX_DIM + k] * b[k*MAX_DIM + c];
        prod[r*MAX_DIM + c] = sum;
      end
    end
  endfunction

  // Works out the matrix a run emits and queues its elements row-major.
  function automatic void predict_power(input result_form_t form, input elem_t diag,
                                        input logic [EXP_BITS-1:0] power);
    grid_t               acc;
    grid_t               squares;
    grid_t               prod;
    logic [EXP_BITS-1:0] bits_left;
    imp_out_t            elem;
    int                  n;
    n = active_dim();
    foreach (acc[i]) acc[i] = '0;
    for (int r = 0; r < n; r++) begin
      case (form)
        EXP_DIAG: acc[r*MAX_DIM + r] = diag;
        EXP_ZERO: acc[r*MAX_DIM + r] = '0;
        default:  acc[r*MAX_DIM + r] = 32'd1;
      endcase
    end
    if (form == EXP_MODEL) begin
      squares   = loaded_elems;
      bits_left = power;
      while (bits_left != 0) begin
        if (bits_left[0]) begin
          mat_mult(prod, acc, squares, n);
          acc = prod;
        end
        bits_left = bits_left >> 1;
        if (bits_left != 0) begin
          mat_mult(prod, squares, squares, n);
          squares = prod;
        end
      end
    end
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        elem.out_row   = IDX_BITS'(r);
        elem.out_col   = IDX_BITS'(c);
        elem.out_value = acc[r*MAX_DIM + c];
        elem.last      = (r == n - 1) && (c == n - 1);
        pending_elems.push_back(elem);
      end
    end
  endfunction

  function automatic imp_in_t make_request(input logic mode, input logic [IDX_BITS-1:0] row,
                                           input logic [IDX_BITS-1:0] col,
                                           input logic [31:0] value,
                                           input logic [EXP_BITS-1:0] power);
    imp_in_t req;
    req.mode          = mode;
    req.row_index     = row;
    req.col_index     = col;
    req.element_value = value;
    req.exponent      = power;
    return req;
  endfunction

  // Small signed values so powers stay readable, the extremes, or
  // anything, with anything the most common pick.
  function automatic logic [31:0] pick_element();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 6) - 32'd3;
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          default: v = 32'd0;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Large sizes get short exponents to keep run times sane; small sizes
  // see exponents of every width up to the full field.
  function automatic logic [EXP_BITS-1:0] pick_power(input int n);
    logic [EXP_BITS-1:0] p;
    if (n >= 6) begin
      p = ($urandom_range(0, 7) == 0) ? EXP_BITS'($urandom_range(0, 255))
                                      : EXP_BITS'($urandom_range(0, 24));
    end else begin
      case ($urandom_range(0, 7))
        0:          p = '0;
        1, 2, 3, 4: p = EXP_BITS'($urandom_range(1, 20));
        5, 6:       p = EXP_BITS'($urandom() >> $urandom_range(1, 31));
        default:    p = EXP_BITS'($urandom() >> 1);
      endcase
    end
    return p;
  endfunction

  // Presents one request and holds it until the block takes it. The sender
  // works in bursts; before a burst, start may drop for a random gap.
  task automatic send_request(input imp_in_t req, input result_form_t form,
                              input elem_t diag);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      gap        = $urandom_range(0, 5);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_data <= req;
    // busy is read as it stood before the edge, which is what the block
    // itself sees when it decides to accept.
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    if (req.mode == MODE_LOAD) begin
      loaded_elems[int'(req.row_index)*MAX_DIM + int'(req.col_index)] = req.element_value;
    end else begin
      predict_power(form, diag, req.exponent);
    end
  endtask

  // The size register may only change while the block is idle: all results
  // in, a few cycles for any trailing work, and busy low.
  task automatic write_size(input logic [DIM_BITS-1:0] value);
    start <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    size_setting  = value;
  endtask

  // Every strobed result is matched against the oldest expected element.
  always @(posedge clk) begin : check_results
    imp_out_t want;
    if (rst_n && out_valid) begin
      if (pending_elems.size() == 0) begin
        $display("%0t: unexpected result row %0d col %0d value %0d last %0b", $time,
                 out_data.out_row, out_data.out_col, out_data.out_value, out_data.last);
        errors++;
      end else begin
        want = pending_elems.pop_front();
        if (out_data.out_row !== want.out_row) begin
          $display("%0t: out_row expected %0d actual %0d", $time, want.out_row,
                   out_data.out_row);
          errors++;
        end
        if (out_data.out_col !== want.out_col) begin
          $display("%0t: out_col expected %0d actual %0d", $time, want.out_col,
                   out_data.out_col);
          errors++;
        end
        if (out_data.out_value !== want.out_value) begin
          $display("%0t: out_value at (%0d,%0d) expected %0d actual %0d", $time,
                   want.out_row, want.out_col, want.out_value, out_data.out_value);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last at (%0d,%0d) expected %0b actual %0b", $time,
                   want.out_row, want.out_col, want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int sent;
    int n;
    int extra;
    int runs;
    foreach (loaded_elems[i]) loaded_elems[i] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      case (script[i].kind)
        STEP_CFG:  write_size(script[i].size);
        STEP_LOAD: send_request(make_request(MODE_LOAD, script[i].row, script[i].col,
                                             script[i].value, EXP_BITS'($urandom())),
                                EXP_MODEL, '0);
        default:   send_request(make_request(MODE_RUN, IDX_BITS'($urandom()),
                                             IDX_BITS'($urandom()), $urandom(),
                                             script[i].power),
                                script[i].form, script[i].diag);
      endcase
    end

    // Random phases: a size, usually a complete matrix load, then a few
    // runs. Stray loads and phases without a run supply the noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       write_size(4'd0);
        1:       write_size(DIM_BITS'($urandom_range(9, 15)));
        2, 3:    write_size(DIM_BITS'($urandom_range(6, 8)));
        default: write_size(DIM_BITS'($urandom_range(1, 5)));
      endcase
      n = active_dim();
      if ($urandom_range(0, 3) != 0) begin
        for (int r = 0; r < n; r++) begin
          for (int c = 0; c < n; c++) begin
            send_request(make_request(MODE_LOAD, IDX_BITS'(r), IDX_BITS'(c), pick_element(),
                                      EXP_BITS'($urandom())), EXP_MODEL, '0);
          end
        end
        sent += n * n;
      end
      extra = $urandom_range(0, 4);
      for (int j = 0; j < extra; j++) begin
        send_request(make_request(MODE_LOAD, IDX_BITS'($urandom()), IDX_BITS'($urandom()),
                                  pick_element(), EXP_BITS'($urandom())), EXP_MODEL, '0);
      end
      sent += extra;
      runs = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
      for (int j = 0; j < runs; j++) begin
        send_request(make_request(MODE_RUN, IDX_BITS'($urandom()), IDX_BITS'($urandom()),
                                  $urandom(), pick_power(n)), EXP_MODEL, '0);
      end
      sent += runs;
    end

    start <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
